// ===== rtl/core/r2fft_pkg.sv =====
`default_nettype none

package r2fft_pkg;

    localparam int POINTS        = 1024;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int TWIDDLE_WIDTH = 16;
    localparam int VAL_W         = 27;
    localparam int MAG_W         = 26;
    localparam int INDEX_W       = 10;
    localparam int LOG_POINTS    = $clog2(POINTS);
    localparam int HALF_POINTS   = POINTS / 2;
    localparam int ADDR_W        = LOG_POINTS;
    localparam int TW_IDX_W      = (LOG_POINTS > 1) ? LOG_POINTS - 1 : 1;
    localparam int STG_W         = $clog2(LOG_POINTS + 1);
    localparam int SQ_W          = 2 * VAL_W;
    localparam int SQRT_STEPS    = VAL_W;
    localparam int SQC_W         = $clog2(SQRT_STEPS + 1);
    localparam int CFG_IDX_W     = 1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL    = 1'b1;

    localparam real PI_R     = 3.14159265358979323846;
    localparam real TW_SCALE = 2.0 ** (TWIDDLE_WIDTH - 1);
    localparam int  TW_MAX   = (1 << (TWIDDLE_WIDTH - 1)) - 1;

    typedef logic signed [VAL_W-1:0]         t_val;
    typedef logic signed [TWIDDLE_WIDTH-1:0] t_tw;
    typedef t_tw t_tw_rom [HALF_POINTS];

    typedef enum logic [4:0] {
        DP_NOP,
        DP_WRSAMP,
        DP_RDBIN,
        DP_BR_RD,
        DP_BR_WA,
        DP_BR_WB,
        DP_BF_RD,
        DP_BF_MUL,
        DP_BF_ADD,
        DP_BF_WA,
        DP_BF_WB,
        DP_SC_RD,
        DP_SC_WR,
        DP_SQ,
        DP_SQSUM,
        DP_SQRT,
        DP_EMIT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BR_RD,
        S_BR_WA,
        S_BR_WB,
        S_BF_RD,
        S_BF_MUL,
        S_BF_ADD,
        S_BF_WA,
        S_BF_WB,
        S_SC_RD,
        S_SC_WR,
        S_RD_SQ,
        S_RD_SUM,
        S_RD_SQRT,
        S_RD_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op            op;
        logic [ADDR_W-1:0] cnt;
        logic [STG_W-1:0]  stage;
        logic              inv;
        logic              real_mode;
    } t_dp_cmd;

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++) begin
            r[b] = v[ADDR_W-1-b];
        end
        return r;
    endfunction

    // Cosine or sine table over the first half circle, mirrored about a quarter.
    function automatic t_tw_rom tw_build(input logic want_sin);
        t_tw_rom rom;
        int      j;
        int      q;
        real     x;
        real     v;
        logic    flip;
        for (int k = 0; k < HALF_POINTS; k++) begin
            flip = (k > POINTS / 4);
            j    = flip ? HALF_POINTS - k : k;
            x    = 2.0 * PI_R * j / POINTS;
            v    = want_sin ? $sin(x) : $cos(x);
            q    = int'($floor(v * TW_SCALE + 0.5));
            if (q < 0) q = 0;
            if (q > TW_MAX) q = TW_MAX;
            rom[k] = (flip && !want_sin) ? -t_tw'(q) : t_tw'(q);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/r2fft_ctrl.sv =====
`default_nettype none

module r2fft_ctrl (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic                               i_cfg_we,
    input  wire logic [r2fft_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic                               i_cfg_data,
    output r2fft_pkg::t_dp_cmd                      o_cmd
);
    import r2fft_pkg::*;

    localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(POINTS - 1);
    localparam logic [ADDR_W-1:0] HALF_LAST = ADDR_W'(HALF_POINTS - 1);
    localparam logic [STG_W-1:0]  STG_LAST  = STG_W'(LOG_POINTS);
    localparam logic [SQC_W-1:0]  SQC_LAST  = SQC_W'(SQRT_STEPS - 1);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [STG_W-1:0]  r_stage, n_stage;
    logic [SQC_W-1:0]  r_sqc, n_sqc;
    logic              r_inverse;
    logic              r_real;
    logic              inv_eff;

    assign inv_eff = r_inverse & ~r_real;
    assign busy    = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_stage   <= '0;
            r_sqc     <= '0;
            r_inverse <= 1'b0;
            r_real    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stage <= n_stage;
            r_sqc   <= n_sqc;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INVERSE: r_inverse <= i_cfg_data;
                    CFG_REAL:    r_real    <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_stage         = r_stage;
        n_sqc           = r_sqc;
        o_cmd.op        = DP_NOP;
        o_cmd.cnt       = r_cnt;
        o_cmd.stage     = r_stage;
        o_cmd.inv       = inv_eff;
        o_cmd.real_mode = r_real;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_opcode)
                        OP_WRITE: o_cmd.op = DP_WRSAMP;
                        OP_RUN: begin
                            n_cnt   = '0;
                            n_state = S_BR_RD;
                        end
                        OP_READ: begin
                            o_cmd.op = DP_RDBIN;
                            n_state  = S_RD_SQ;
                        end
                        default: ;
                    endcase
                end
            end
            S_BR_RD: begin
                if (r_cnt > bit_rev(r_cnt)) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    o_cmd.op = DP_BR_RD;
                    n_state  = S_BR_WA;
                end
            end
            S_BR_WA: begin
                o_cmd.op = DP_BR_WA;
                n_state  = S_BR_WB;
            end
            S_BR_WB: begin
                o_cmd.op = DP_BR_WB;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_stage = STG_W'(1);
                    n_state = S_BF_RD;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_BR_RD;
                end
            end
            S_BF_RD: begin
                o_cmd.op = DP_BF_RD;
                n_state  = S_BF_MUL;
            end
            S_BF_MUL: begin
                o_cmd.op = DP_BF_MUL;
                n_state  = S_BF_ADD;
            end
            S_BF_ADD: begin
                o_cmd.op = DP_BF_ADD;
                n_state  = S_BF_WA;
            end
            S_BF_WA: begin
                o_cmd.op = DP_BF_WA;
                n_state  = S_BF_WB;
            end
            S_BF_WB: begin
                o_cmd.op = DP_BF_WB;
                if (r_cnt == HALF_LAST) begin
                    n_cnt = '0;
                    if (r_stage == STG_LAST) begin
                        n_state = inv_eff ? S_SC_RD : S_IDLE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_state = S_BF_RD;
                    end
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_BF_RD;
                end
            end
            S_SC_RD: begin
                o_cmd.op = DP_SC_RD;
                n_state  = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.op = DP_SC_WR;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_RD_SQ: begin
                o_cmd.op = DP_SQ;
                n_state  = S_RD_SUM;
            end
            S_RD_SUM: begin
                o_cmd.op = DP_SQSUM;
                n_sqc    = '0;
                n_state  = S_RD_SQRT;
            end
            S_RD_SQRT: begin
                o_cmd.op = DP_SQRT;
                if (r_sqc == SQC_LAST) begin
                    n_state = S_RD_EMIT;
                end else begin
                    n_sqc = r_sqc + 1'b1;
                end
            end
            S_RD_EMIT: begin
                o_cmd.op = DP_EMIT;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/r2fft_dp.sv =====
`default_nettype none

module r2fft_dp (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire r2fft_pkg::t_dp_cmd                        i_cmd,
    input  wire logic [r2fft_pkg::INDEX_W-1:0]             i_index,
    input  wire logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] i_sample_re,
    input  wire logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] i_sample_im,
    output logic                                           o_valid,
    output logic signed [r2fft_pkg::VAL_W-1:0]             o_bin_re,
    output logic signed [r2fft_pkg::VAL_W-1:0]             o_bin_im,
    output logic [r2fft_pkg::MAG_W-1:0]                    o_magnitude,
    output logic                                           o_out_of_range
);
    import r2fft_pkg::*;

    localparam int PROD_W = VAL_W + TWIDDLE_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (TWIDDLE_WIDTH - 2);
    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(1 << (VAL_W - 1));
    localparam logic [SQ_W-1:0] MAG_MAX = SQ_W'((1 << MAG_W) - 1);
    localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (SQ_W - 2);
    localparam logic [ADDR_W-1:0] OOR_LIM = ADDR_W'(HALF_POINTS);
    localparam t_tw_rom ROM_COS = tw_build(1'b0);
    localparam t_tw_rom ROM_SIN = tw_build(1'b1);

    function automatic t_val sat_val(input logic signed [SUM_W-1:0] v);
        if (v > VMAX) return t_val'(VMAX);
        if (v < VMIN) return t_val'(VMIN);
        return t_val'(v);
    endfunction

    logic [2*VAL_W-1:0] mem [POINTS];

    logic [ADDR_W-1:0]        idx;
    logic [ADDR_W-1:0]        ra0, ra1, wa;
    logic [2*VAL_W-1:0]       wd;
    logic                     re0, re1, we;
    logic [STG_W-1:0]         sh;
    logic [ADDR_W-1:0]        half, k_off, addr_a, addr_b;
    logic [TW_IDX_W-1:0]      tw_idx;
    logic signed [SUM_W-1:0]  s_r, s_i, t_r, t_i;
    logic [SQ_W-1:0]          sq_try;

    logic [2*VAL_W-1:0]       r_rd0, r_rd1;
    t_val                     rd0_re, rd0_im, rd1_re, rd1_im;
    t_tw                      r_wr, r_wi;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic [2*VAL_W-1:0]       r_na, r_nb;
    logic signed [SQ_W-1:0]   r_sq_re, r_sq_im;
    logic [SQ_W-1:0]          r_v, r_r, r_bit;
    logic                     r_oor;
    logic                     r_valid;
    t_val                     r_out_re, r_out_im;
    logic [MAG_W-1:0]         r_out_mag;
    logic                     r_out_oor;

    assign idx    = i_index[ADDR_W-1:0];
    assign rd0_re = r_rd0[2*VAL_W-1:VAL_W];
    assign rd0_im = r_rd0[VAL_W-1:0];
    assign rd1_re = r_rd1[2*VAL_W-1:VAL_W];
    assign rd1_im = r_rd1[VAL_W-1:0];

    // butterfly addressing for the current stage
    assign sh     = i_cmd.stage - 1'b1;
    assign half   = ADDR_W'(1) << sh;
    assign k_off  = i_cmd.cnt & (half - 1'b1);
    assign addr_a = ((i_cmd.cnt >> sh) << i_cmd.stage) | k_off;
    assign addr_b = addr_a | half;
    assign tw_idx = TW_IDX_W'(k_off << (STG_W'(LOG_POINTS) - i_cmd.stage));

    always_comb begin
        ra0 = i_cmd.cnt;
        ra1 = bit_rev(i_cmd.cnt);
        re0 = 1'b0;
        re1 = 1'b0;
        we  = 1'b0;
        wa  = i_cmd.cnt;
        wd  = r_rd0;
        unique case (i_cmd.op)
            DP_WRSAMP: begin
                we = 1'b1;
                wa = idx;
                wd = {VAL_W'(i_sample_re), VAL_W'(i_sample_im)};
            end
            DP_RDBIN: begin
                re0 = 1'b1;
                ra0 = idx;
            end
            DP_BR_RD: begin
                re0 = 1'b1;
                re1 = 1'b1;
            end
            DP_BR_WA: begin
                we = 1'b1;
                wd = {rd1_re, i_cmd.real_mode ? t_val'(0) : rd1_im};
            end
            DP_BR_WB: begin
                we = 1'b1;
                wa = bit_rev(i_cmd.cnt);
                wd = {rd0_re, i_cmd.real_mode ? t_val'(0) : rd0_im};
            end
            DP_BF_RD: begin
                re0 = 1'b1;
                re1 = 1'b1;
                ra0 = addr_a;
                ra1 = addr_b;
            end
            DP_BF_WA: begin
                we = 1'b1;
                wa = addr_a;
                wd = r_na;
            end
            DP_BF_WB: begin
                we = 1'b1;
                wa = addr_b;
                wd = r_nb;
            end
            DP_SC_RD: re0 = 1'b1;
            DP_SC_WR: begin
                we = 1'b1;
                wd = {rd0_re >>> LOG_POINTS, rd0_im >>> LOG_POINTS};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (re0) r_rd0 <= mem[ra0];
        if (re1) r_rd1 <= mem[ra1];
    end

    // rounded twiddle products and saturated butterfly sums
    assign s_r    = SUM_W'(r_p_rr) - SUM_W'(r_p_ii) + RND;
    assign s_i    = SUM_W'(r_p_ri) + SUM_W'(r_p_ir) + RND;
    assign t_r    = s_r >>> (TWIDDLE_WIDTH - 1);
    assign t_i    = s_i >>> (TWIDDLE_WIDTH - 1);
    assign sq_try = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_RDBIN: r_oor <= i_cmd.real_mode && (idx > OOR_LIM);
            DP_BF_RD: begin
                r_wr <= ROM_COS[tw_idx];
                r_wi <= i_cmd.inv ? ROM_SIN[tw_idx] : -ROM_SIN[tw_idx];
            end
            DP_BF_MUL: begin
                r_p_rr <= rd1_re * r_wr;
                r_p_ii <= rd1_im * r_wi;
                r_p_ri <= rd1_re * r_wi;
                r_p_ir <= rd1_im * r_wr;
            end
            DP_BF_ADD: begin
                r_na <= {sat_val(SUM_W'(rd0_re) + t_r), sat_val(SUM_W'(rd0_im) + t_i)};
                r_nb <= {sat_val(SUM_W'(rd0_re) - t_r), sat_val(SUM_W'(rd0_im) - t_i)};
            end
            DP_SQ: begin
                r_sq_re <= rd0_re * rd0_re;
                r_sq_im <= rd0_im * rd0_im;
            end
            DP_SQSUM: begin
                r_v   <= SQ_W'(r_sq_re) + SQ_W'(r_sq_im);
                r_r   <= '0;
                r_bit <= BIT_TOP;
            end
            DP_SQRT: begin
                if (r_v >= sq_try) begin
                    r_v <= r_v - sq_try;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            DP_EMIT: begin
                r_out_oor <= r_oor;
                r_out_re  <= r_oor ? t_val'(0) : rd0_re;
                r_out_im  <= r_oor ? t_val'(0) : rd0_im;
                if (r_oor) begin
                    r_out_mag <= '0;
                end else if (r_r > MAG_MAX) begin
                    r_out_mag <= MAG_MAX[MAG_W-1:0];
                end else begin
                    r_out_mag <= r_r[MAG_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == DP_EMIT);
        end
    end

    assign o_valid        = r_valid;
    assign o_bin_re       = r_out_re;
    assign o_bin_im       = r_out_im;
    assign o_magnitude    = r_out_mag;
    assign o_out_of_range = r_out_oor;

endmodule

`default_nettype wire

// ===== rtl/core/radix2_fft_engine_core.sv =====
`default_nettype none

// In-place radix-2 decimation-in-time FFT over a stored frame of 1024 points.
// Command channel: present an opcode, index and sample with start high while
// busy is low; the beat is taken at that edge.
//   write: stores one sample, done in the accept cycle, busy stays low.
//   run:   bit-reverse pass (each index not above its reverse is read, then
//          written at the index and at its reverse; other indices are skipped),
//          then a read, multiply, add, write A and write B for each of 512
//          butterflies x 10 stages, plus a 1/N scaling pass (read, then write
//          each point) when inverse and not in real mode; no two steps overlap.
//   read:  one result beat after the bin is read, squared and summed and its
//          magnitude square root resolves, one result bit per cycle.
// Result channel: o_valid strobes for one cycle with the bin fields; the
// receiver cannot stall, so each result is shown exactly once.
// Configuration: i_cfg_we with i_cfg_index selects inverse mode (0) or real
// input mode (1); write only while idle.
// Reset clears the controller and config registers; the frame memory is not
// cleared and holds garbage until written.
module radix2_fft_engine_core (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire logic [1:0]                                i_opcode,
    input  wire logic [r2fft_pkg::INDEX_W-1:0]             i_index,
    input  wire logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] i_sample_re,
    input  wire logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] i_sample_im,
    input  wire logic                                      i_cfg_we,
    input  wire logic [r2fft_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic                                      i_cfg_data,
    output logic                                           o_valid,
    output logic signed [r2fft_pkg::VAL_W-1:0]             o_bin_re,
    output logic signed [r2fft_pkg::VAL_W-1:0]             o_bin_im,
    output logic [r2fft_pkg::MAG_W-1:0]                    o_magnitude,
    output logic                                           o_out_of_range
);
    import r2fft_pkg::*;

    // command bundle from sequencer to datapath
    t_dp_cmd cmd;

    r2fft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd)
    );

    // frame memory, twiddle ROM, butterfly and magnitude units
    r2fft_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_index        (i_index),
        .i_sample_re    (i_sample_re),
        .i_sample_im    (i_sample_im),
        .o_valid        (o_valid),
        .o_bin_re       (o_bin_re),
        .o_bin_im       (o_bin_im),
        .o_magnitude    (o_magnitude),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire
